### hdl/seven_segment_two_wire_display_driver_assert.svh
// Assertion macros for the display driver sequencer (ssd_seq).
// Each property is clocked on clk and switched off while rst is high.
`ifndef SEVEN_SEGMENT_TWO_WIRE_DISPLAY_DRIVER_ASSERT_SVH
`define SEVEN_SEGMENT_TWO_WIRE_DISPLAY_DRIVER_ASSERT_SVH
`ifndef SYNTH
`define SSD_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("display driver assertion failed");
`define SSD_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("display driver assertion failed");
`else
`define SSD_ASSERT(name, prop)
`define SSD_ASSERT_NEXT(name, pre, post)
`endif
`endif

### hdl/ssd_pkg.sv
package ssd_pkg;

  localparam int DIGITS = 4;

  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_DEC   = 3'd1;
  localparam logic [2:0] MODE_HEX   = 3'd2;
  localparam logic [2:0] MODE_CLOCK = 3'd3;
  localparam logic [2:0] MODE_DASH  = 3'd4;

  localparam logic [1:0] CFG_BRIGHTNESS = 2'd0;
  localparam logic [1:0] CFG_DISPLAY_ON = 2'd1;
  localparam logic [1:0] CFG_LEAD_ZEROS = 2'd2;

  localparam logic [7:0] CMD_DATA   = 8'h40;
  localparam logic [7:0] CMD_ADDR   = 8'hC0;
  localparam logic [7:0] CMD_CTRL   = 8'h80;
  localparam logic [7:0] CTRL_ON    = 8'h08;
  localparam logic [7:0] SEG_COLON  = 8'h80;
  localparam logic [7:0] SEG_DASH   = 8'h40;
  localparam logic [7:0] SEG_BLANK  = 8'h00;

  typedef logic [7:0] seg_byte_t;
  typedef seg_byte_t [DIGITS-1:0] seg_buf_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] value;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic        dio_in;
  } item_t;

  typedef struct packed {
    logic clk_out;
    logic dio_out;
    logic busy_res;
    logic ack_level;
    logic dropped;
  } result_t;

  // Segment patterns for the hexadecimal digits, bit 6..0 are segments G..A.
  function automatic seg_byte_t seg_of(input logic [3:0] digit);
    seg_byte_t s;
    case (digit)
      4'h0: s = 8'h3F;
      4'h1: s = 8'h06;
      4'h2: s = 8'h5B;
      4'h3: s = 8'h4F;
      4'h4: s = 8'h66;
      4'h5: s = 8'h6D;
      4'h6: s = 8'h7D;
      4'h7: s = 8'h07;
      4'h8: s = 8'h7F;
      4'h9: s = 8'h6F;
      4'hA: s = 8'h77;
      4'hB: s = 8'h7C;
      4'hC: s = 8'h39;
      4'hD: s = 8'h5E;
      4'hE: s = 8'h79;
      default: s = 8'h71;
    endcase
    return s;
  endfunction

endpackage

### hdl/seven_segment_two_wire_display_driver.sv
// Four-digit seven-segment display driver on a two-wire bit-banged link. Every
// accepted item gives exactly one result: one item per clock cycle sustained while
// out_ready is high, with the item going from the input register through one
// sequencer step into the result register. A tick item moves
// the clk/dio lines by one step;
// a request item (decimal, hex, clock, dashes) starts a three-frame transfer
// while the lines hold, and is dropped with a flag if a transfer is running.
// The segment bytes are formed by a small converter that starts when the
// sequencer takes the request and fills seg_buf well before the first segment
// byte goes on the wire.
module seven_segment_two_wire_display_driver (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [15:0] value,
  input  logic [6:0]  hour,
  input  logic [6:0]  minute,
  input  logic        dio_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        clk_out,
  output logic        dio_out,
  output logic        busy_res,
  output logic        ack_level,
  output logic        dropped,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data
);

  logic              in_v;
  ssd_pkg::item_t    item_q;
  logic              take;
  logic              load;
  logic [2:0]        brightness;
  logic              display_on;
  logic              show_leading_zeros;
  ssd_pkg::seg_buf_t seg_buf;
  ssd_pkg::result_t  res_q;

  assign in_ready = !in_v || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v <= 1'b1;
    end else if (take) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q <= '{mode: mode, value: value, hour: hour, minute: minute, dio_in: dio_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness         <= 3'd7;
      display_on         <= 1'b1;
      show_leading_zeros <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ssd_pkg::CFG_BRIGHTNESS: brightness         <= cfg_data;
        ssd_pkg::CFG_DISPLAY_ON: display_on         <= cfg_data[0];
        ssd_pkg::CFG_LEAD_ZEROS: show_leading_zeros <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  ssd_digits u_digits (
    .clk        (clk),
    .rst        (rst),
    .start      (load),
    .item       (item_q),
    .lead_zeros (show_leading_zeros),
    .seg_buf    (seg_buf)
  );

  ssd_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_v       (in_v),
    .item       (item_q),
    .brightness (brightness),
    .display_on (display_on),
    .seg_buf    (seg_buf),
    .out_ready  (out_ready),
    .take       (take),
    .load       (load),
    .out_valid  (out_valid),
    .res_q      (res_q)
  );

  assign clk_out   = res_q.clk_out;
  assign dio_out   = res_q.dio_out;
  assign busy_res  = res_q.busy_res;
  assign ack_level = res_q.ack_level;
  assign dropped   = res_q.dropped;

endmodule

### hdl/ssd_digits.sv
module ssd_digits (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  ssd_pkg::item_t  item,
  input  logic            lead_zeros,
  output ssd_pkg::seg_buf_t seg_buf
);

  typedef enum logic [1:0] {C_IDLE, C_MOD, C_DIG, C_FILL} cstate_t;

  localparam int MOD_BASE = 10000;

  cstate_t          state;
  logic [2:0]       kind;
  logic             lz;
  logic [15:0]      num;
  logic [1:0]       didx;
  logic [3:0]       dig [ssd_pkg::DIGITS];

  logic [2:0]       mod_q;
  logic [15:0]      num_mod;
  logic [9:0]       weight;
  logic [3:0]       dsel;
  logic [15:0]      num_rem;
  ssd_pkg::seg_buf_t fill_num;
  logic             seen;

  // Tens and units of a 7-bit value; x*205>>11 equals x/10 below 1029.
  function automatic logic [7:0] split10(input logic [6:0] x);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    prod = 15'(x) * 15'd205;
    q = prod[14:11];
    r = x - 7'(q) * 7'd10;
    return {q, r[3:0]};
  endfunction

  always_comb begin
    mod_q = '0;
    for (int k = 1; k <= 6; k++) begin
      if (num >= 16'(k * MOD_BASE)) mod_q = 3'(k);
    end
    num_mod = num - 16'(mod_q * 16'(MOD_BASE));
  end

  always_comb begin
    case (didx)
      2'd0: weight = 10'd1000;
      2'd1: weight = 10'd100;
      default: weight = 10'd10;
    endcase
    dsel = '0;
    for (int k = 1; k <= 9; k++) begin
      if (num >= 16'(k) * {6'd0, weight}) dsel = 4'(k);
    end
    num_rem = num - {12'd0, dsel} * {6'd0, weight};
  end

  // Leading-zero blanking for decimal and hex.
  always_comb begin
    seen = lz;
    for (int i = 0; i < ssd_pkg::DIGITS; i++) begin
      if (dig[i] == 4'd0 && !seen) begin
        fill_num[i] = ssd_pkg::SEG_BLANK;
      end else begin
        fill_num[i] = ssd_pkg::seg_of(dig[i]);
        seen = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      case (state)
        C_IDLE: begin
          if (start) begin
            kind <= item.mode;
            lz   <= lead_zeros;
            num  <= item.value;
            didx <= 2'd0;
            if (item.mode == ssd_pkg::MODE_HEX) begin
              dig[0] <= item.value[15:12];
              dig[1] <= item.value[11:8];
              dig[2] <= item.value[7:4];
              dig[3] <= item.value[3:0];
            end else begin
              {dig[0], dig[1]} <= split10(item.hour);
              {dig[2], dig[3]} <= split10(item.minute);
            end
            if (item.mode == ssd_pkg::MODE_DEC) begin
              state <= C_MOD;
            end else begin
              state <= C_FILL;
            end
          end
        end
        C_MOD: begin
          num   <= num_mod;
          state <= C_DIG;
        end
        C_DIG: begin
          dig[didx] <= dsel;
          num       <= num_rem;
          didx      <= didx + 2'd1;
          if (didx == 2'd2) begin
            dig[3] <= num_rem[3:0];
            state  <= C_FILL;
          end
        end
        C_FILL: begin
          case (kind)
            ssd_pkg::MODE_DEC, ssd_pkg::MODE_HEX: seg_buf <= fill_num;
            ssd_pkg::MODE_CLOCK: begin
              seg_buf[0] <= ssd_pkg::seg_of(dig[0]);
              seg_buf[1] <= ssd_pkg::seg_of(dig[1]) | ssd_pkg::SEG_COLON;
              seg_buf[2] <= ssd_pkg::seg_of(dig[2]);
              seg_buf[3] <= ssd_pkg::seg_of(dig[3]);
            end
            default: seg_buf <= {ssd_pkg::DIGITS{ssd_pkg::SEG_DASH}};
          endcase
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

### hdl/ssd_seq.sv
module ssd_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_v,
  input  ssd_pkg::item_t    item,
  input  logic [2:0]        brightness,
  input  logic              display_on,
  input  ssd_pkg::seg_buf_t seg_buf,
  input  logic              out_ready,
  output logic              take,
  output logic              load,
  output logic              out_valid,
  output ssd_pkg::result_t  res_q
);

  `include "seven_segment_two_wire_display_driver_assert.svh"

  typedef enum logic [1:0] {PH_START, PH_BITS, PH_ACK, PH_STOP} phase_t;

  localparam logic [3:0] SLOT_ADDR = 4'd1;
  localparam logic [3:0] SLOT_SEG0 = 4'd2;
  localparam logic [3:0] SLOT_LAST_SEG = 4'd5;
  localparam logic [3:0] SLOT_CTRL = 4'd6;

  logic       active, active_next;
  phase_t     phase, phase_next;
  logic [2:0] step, step_next;
  logic [2:0] bit_index, bit_index_next;
  logic [3:0] byte_slot, byte_slot_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic       last_ack, last_ack_next;
  logic       clk_level, clk_level_next;
  logic       dio_level, dio_level_next;
  logic       dropped_next;
  logic [3:0] slot_inc;

  function automatic logic [7:0] byte_for(input logic [3:0] slot,
                                          input ssd_pkg::seg_buf_t buf_in,
                                          input logic on, input logic [2:0] br);
    logic [3:0] rel;
    rel = slot - SLOT_SEG0;
    if (slot == 4'd0) return ssd_pkg::CMD_DATA;
    if (slot == SLOT_ADDR) return ssd_pkg::CMD_ADDR;
    if (slot >= SLOT_SEG0 && slot <= SLOT_LAST_SEG) return buf_in[rel[1:0]];
    return ssd_pkg::CMD_CTRL | (on ? ssd_pkg::CTRL_ON : 8'h00) | {5'd0, br};
  endfunction

  assign take     = in_v && (!out_valid || out_ready);
  assign slot_inc = byte_slot + 4'd1;

  always_comb begin
    active_next     = active;
    phase_next      = phase;
    step_next       = step;
    bit_index_next  = bit_index;
    byte_slot_next  = byte_slot;
    shift_byte_next = shift_byte;
    last_ack_next   = last_ack;
    clk_level_next  = clk_level;
    dio_level_next  = dio_level;
    dropped_next    = 1'b0;
    load            = 1'b0;
    case (item.mode)
      ssd_pkg::MODE_TICK: begin
        if (active) begin
          case (phase)
            PH_START: begin
              dio_level_next  = 1'b0;
              phase_next      = PH_BITS;
              step_next       = 3'd0;
              bit_index_next  = 3'd0;
              shift_byte_next = byte_for(byte_slot, seg_buf, display_on, brightness);
            end
            PH_BITS: begin
              if (step == 3'd0) begin
                clk_level_next = 1'b0;
                step_next      = 3'd1;
              end else if (step == 3'd1) begin
                dio_level_next = shift_byte[0];
                step_next      = 3'd2;
              end else begin
                clk_level_next  = 1'b1;
                shift_byte_next = {1'b0, shift_byte[7:1]};
                step_next       = 3'd0;
                if (bit_index == 3'd7) begin
                  phase_next     = PH_ACK;
                  bit_index_next = 3'd0;
                end else begin
                  bit_index_next = bit_index + 3'd1;
                end
              end
            end
            PH_ACK: begin
              case (step)
                3'd0: clk_level_next = 1'b0;
                3'd1: dio_level_next = 1'b1;
                3'd2: begin
                  last_ack_next  = item.dio_in;
                  dio_level_next = 1'b0;
                end
                3'd3: clk_level_next = 1'b1;
                default: clk_level_next = 1'b0;
              endcase
              if (step < 3'd4) begin
                step_next = step + 3'd1;
              end else begin
                step_next = 3'd0;
                // The data command frame, the last display byte and the control byte end in a stop.
                if (byte_slot == 4'd0 || byte_slot >= SLOT_LAST_SEG) begin
                  phase_next = PH_STOP;
                end else begin
                  byte_slot_next  = slot_inc;
                  phase_next      = PH_BITS;
                  bit_index_next  = 3'd0;
                  shift_byte_next = byte_for(slot_inc, seg_buf, display_on, brightness);
                end
              end
            end
            default: begin
              if (step == 3'd0) begin
                dio_level_next = 1'b0;
                step_next      = 3'd1;
              end else if (step == 3'd1) begin
                clk_level_next = 1'b1;
                step_next      = 3'd2;
              end else begin
                dio_level_next = 1'b1;
                step_next      = 3'd0;
                phase_next     = PH_START;
                if (byte_slot >= SLOT_CTRL) begin
                  active_next    = 1'b0;
                  byte_slot_next = 4'd0;
                end else begin
                  byte_slot_next = (byte_slot == 4'd0) ? SLOT_ADDR : SLOT_CTRL;
                end
              end
            end
          endcase
        end
      end
      ssd_pkg::MODE_DEC, ssd_pkg::MODE_HEX, ssd_pkg::MODE_CLOCK, ssd_pkg::MODE_DASH: begin
        if (active) begin
          dropped_next = 1'b1;
        end else begin
          load           = take;
          active_next    = 1'b1;
          phase_next     = PH_START;
          step_next      = 3'd0;
          bit_index_next = 3'd0;
          byte_slot_next = 4'd0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      phase      <= PH_START;
      step       <= 3'd0;
      bit_index  <= 3'd0;
      byte_slot  <= 4'd0;
      shift_byte <= 8'd0;
      last_ack   <= 1'b0;
      clk_level  <= 1'b1;
      dio_level  <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        active     <= active_next;
        phase      <= phase_next;
        step       <= step_next;
        bit_index  <= bit_index_next;
        byte_slot  <= byte_slot_next;
        shift_byte <= shift_byte_next;
        last_ack   <= last_ack_next;
        clk_level  <= clk_level_next;
        dio_level  <= dio_level_next;
        out_valid  <= 1'b1;
        res_q      <= '{clk_out: clk_level_next, dio_out: dio_level_next,
                        busy_res: active_next, ack_level: last_ack_next,
                        dropped: dropped_next};
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SSD_ASSERT(a_idle_lines_released, !active |-> (clk_level && dio_level))
  `SSD_ASSERT(a_bit_index_outside_bits, (phase != PH_BITS) |-> (bit_index == 3'd0))
  `SSD_ASSERT(a_slot_in_range, byte_slot <= SLOT_CTRL)
  `SSD_ASSERT_NEXT(a_drop_only_when_busy, take && dropped_next, res_q.dropped && res_q.busy_res)

endmodule
